// ----- rtl/tslne_pkg.sv -----
// Package for the text stream line number and escape unit: constants, codes and types.
package tslne_pkg;

   localparam int NUMBER_DIGITS = 6;
   localparam int POS_W = $clog2(NUMBER_DIGITS + 3);
   localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_NONBLANK = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_ALL      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SQUEEZE_BLANK   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENDS_VISIBLE    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENDS_ONLY       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABS_VISIBLE    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABS_ONLY       = 3'd6;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_DEL     = 8'o177;
   localparam logic [7:0] CHAR_CTRL_HI = 8'd31;
   localparam logic [7:0] CHAR_SHIFT   = 8'd64;
   localparam logic [7:0] CHAR_QUEST   = 8'h3F;
   localparam logic [7:0] CHAR_CARET   = 8'h5E;
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [3:0] BCD_NINE     = 4'd9;

   typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_type;

   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squeeze_blank;
      logic ends_visible;
      logic ends_only;
      logic tabs_visible;
      logic tabs_only;
   } cfg_type;

   typedef struct packed {
      logic    prev_newline;
      logic    blank_printed;
      bcd_type line_count;
   } line_state_type;

   typedef struct packed {
      logic                          numbered;
      logic                          has_prefix;
      logic [7:0]                    prefix;
      logic [7:0]                    main;
      logic [NUMBER_DIGITS-1:0][7:0] num_chars;
   } run_type;

endpackage

// ----- rtl/tslne_fmt.sv -----
// Per-byte formatter: line number, caret and dollar decisions and the next line state.
module tslne_fmt (
   input  logic [7:0]              in_byte,
   input  tslne_pkg::cfg_type      cfg,
   input  tslne_pkg::line_state_type cur,
   output logic                    drop,
   output tslne_pkg::line_state_type nxt,
   output tslne_pkg::run_type      run
);

   logic              is_nl;
   logic              numbered;
   logic              caret;
   logic              caret_conv;
   logic              tab_mode;
   logic              is_ctrl;
   logic              all_nines;
   logic              carry;
   logic              nonzero;
   tslne_pkg::bcd_type inc_count;
   tslne_pkg::bcd_type shown;
   logic [3:0]        dig;

   always_comb begin
      is_nl = (in_byte == tslne_pkg::CHAR_NEWLINE);
      drop  = is_nl && cur.blank_printed && cfg.squeeze_blank;

      if (cfg.number_nonblank) begin
         numbered = !is_nl && cur.prev_newline;
      end else begin
         numbered = cfg.number_all && cur.prev_newline;
      end

      // BCD increment, saturating at all nines
      all_nines = 1'b1;
      for (int i = 0; i < tslne_pkg::NUMBER_DIGITS; i++) begin
         if (cur.line_count[i] != tslne_pkg::BCD_NINE) all_nines = 1'b0;
      end
      carry = 1'b1;
      inc_count = cur.line_count;
      for (int i = 0; i < tslne_pkg::NUMBER_DIGITS; i++) begin
         if (carry) begin
            if (cur.line_count[i] == tslne_pkg::BCD_NINE) begin
               inc_count[i] = 4'd0;
            end else begin
               inc_count[i] = cur.line_count[i] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      shown = all_nines ? cur.line_count : inc_count;

      // display position 0 is the most significant digit
      nonzero = 1'b0;
      for (int p = 0; p < tslne_pkg::NUMBER_DIGITS; p++) begin
         dig = shown[tslne_pkg::NUMBER_DIGITS-1-p];
         if (dig != 4'd0) nonzero = 1'b1;
         if (!nonzero && p != tslne_pkg::NUMBER_DIGITS - 1) begin
            run.num_chars[p] = tslne_pkg::CHAR_SPACE;
         end else begin
            run.num_chars[p] = tslne_pkg::CHAR_ZERO + {4'd0, dig};
         end
      end

      caret_conv = cfg.ends_visible && !cfg.ends_only;
      tab_mode   = cfg.tabs_visible != cfg.tabs_only;
      is_ctrl    = (in_byte <= tslne_pkg::CHAR_CTRL_HI) && !is_nl;
      caret = 1'b0;
      if (caret_conv && (in_byte[7] || in_byte == tslne_pkg::CHAR_DEL ||
                         (is_ctrl && in_byte != tslne_pkg::CHAR_TAB))) caret = 1'b1;
      if (tab_mode && in_byte == tslne_pkg::CHAR_TAB) caret = 1'b1;
      if (cfg.tabs_visible && !cfg.tabs_only &&
          (in_byte == tslne_pkg::CHAR_DEL || is_ctrl)) caret = 1'b1;

      run.numbered = numbered;
      if (caret) begin
         run.has_prefix = 1'b1;
         run.prefix     = tslne_pkg::CHAR_CARET;
         run.main       = (in_byte == tslne_pkg::CHAR_DEL) ? tslne_pkg::CHAR_QUEST
                                                           : in_byte + tslne_pkg::CHAR_SHIFT;
      end else begin
         run.has_prefix = is_nl && (cfg.ends_visible || cfg.ends_only);
         run.prefix     = tslne_pkg::CHAR_DOLLAR;
         run.main       = in_byte;
      end

      if (drop) begin
         nxt = cur;
      end else begin
         nxt.prev_newline  = is_nl;
         nxt.blank_printed = cur.prev_newline && is_nl;
         nxt.line_count    = numbered ? shown : cur.line_count;
      end
   end

endmodule

// ----- rtl/text_stream_line_number_escape_unit.sv -----
// Top level of the text stream line number and escape unit.
// The first result byte is registered: it is presented in the cycle after the input transfer.
// An input byte yields 1 to 9 result bytes, held in the output register until each one
// transfers; a squeezed newline yields no result bytes. Next input is taken
// in the cycle the last byte of the current run transfers.
// Reset: synchronous; clears configuration, line count to zero, start-of-line flag set, output empty.
module text_stream_line_number_escape_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] in_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] out_byte
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [tslne_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                              csr_wdata
);

   tslne_pkg::cfg_type        cfg_ff;
   tslne_pkg::line_state_type st_ff;
   tslne_pkg::line_state_type st_in;
   tslne_pkg::run_type        run_ff;
   tslne_pkg::run_type        run_in;
   logic                      run_valid_ff;
   logic [tslne_pkg::POS_W-1:0] pos_ff;
   logic                      drop;
   logic                      req_xfer;
   logic                      rsp_xfer;
   logic [tslne_pkg::POS_W-1:0] tail;

   tslne_fmt u_fmt (
      .in_byte (req_tdata),
      .cfg     (cfg_ff),
      .cur     (st_ff),
      .drop    (drop),
      .nxt     (st_in),
      .run     (run_in)
   );

   always_comb begin
      tail = run_ff.numbered ? pos_ff - tslne_pkg::POS_W'(tslne_pkg::NUMBER_DIGITS + 1)
                             : pos_ff;
      rsp_tlast = (tail == {{(tslne_pkg::POS_W-1){1'b0}}, run_ff.has_prefix});
      if (run_ff.numbered && pos_ff < tslne_pkg::POS_W'(tslne_pkg::NUMBER_DIGITS)) begin
         rsp_tdata = run_ff.num_chars[pos_ff[tslne_pkg::DIG_W-1:0]];
      end else if (run_ff.numbered && pos_ff == tslne_pkg::POS_W'(tslne_pkg::NUMBER_DIGITS)) begin
         rsp_tdata = tslne_pkg::CHAR_TAB;
      end else if (tail == '0 && run_ff.has_prefix) begin
         rsp_tdata = run_ff.prefix;
      end else begin
         rsp_tdata = run_ff.main;
      end
   end

   assign rsp_tvalid = run_valid_ff;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign req_tready = !run_valid_ff || (rsp_tready && rsp_tlast);
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tslne_pkg::CSR_NUMBER_NONBLANK: cfg_ff.number_nonblank <= csr_wdata;
            tslne_pkg::CSR_NUMBER_ALL:      cfg_ff.number_all      <= csr_wdata;
            tslne_pkg::CSR_SQUEEZE_BLANK:   cfg_ff.squeeze_blank   <= csr_wdata;
            tslne_pkg::CSR_ENDS_VISIBLE:    cfg_ff.ends_visible    <= csr_wdata;
            tslne_pkg::CSR_ENDS_ONLY:       cfg_ff.ends_only       <= csr_wdata;
            tslne_pkg::CSR_TABS_VISIBLE:    cfg_ff.tabs_visible    <= csr_wdata;
            tslne_pkg::CSR_TABS_ONLY:       cfg_ff.tabs_only       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.prev_newline  <= 1'b1;
         st_ff.blank_printed <= 1'b0;
         st_ff.line_count    <= '0;
         run_valid_ff        <= 1'b0;
         pos_ff              <= '0;
      end else begin
         if (req_xfer) begin
            st_ff <= st_in;
         end
         if (req_xfer && !drop) begin
            run_valid_ff <= 1'b1;
            pos_ff       <= '0;
         end else if (rsp_xfer) begin
            if (rsp_tlast) begin
               run_valid_ff <= 1'b0;
               pos_ff       <= '0;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && !drop) begin
         run_ff <= run_in;
      end
   end

`ifndef SYNTHESIS
   generate
      for (genvar g = 0; g < tslne_pkg::NUMBER_DIGITS; g++) begin : g_bcd_chk
         a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
            st_ff.line_count[g] <= tslne_pkg::BCD_NINE)
            else $error("line count digit not BCD");
      end
   endgenerate

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= tslne_pkg::POS_W'(tslne_pkg::NUMBER_DIGITS + 2))
      else $error("output position out of range");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_tlast) |=> (rsp_tvalid && pos_ff == $past(pos_ff) + 1'b1))
      else $error("run ended early");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (st_ff.line_count == '0 && st_ff.prev_newline && !run_valid_ff))
      else $error("reset state wrong");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> $stable(st_ff))
      else $error("line state changed without input transfer");
`endif

endmodule
